// ===== rtl/at_response_parser_assert.svh =====
// Assertion macros for the modem reply parser checkers.
// Needs nothing else; included by the checker file.
`ifndef AT_RESPONSE_PARSER_ASSERT_SVH
`define AT_RESPONSE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("at_response_parser: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("at_response_parser: assertion failed");

`endif

// ===== rtl/atrp_pkg.sv =====
// Shared types and constants of the modem reply parser.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package atrp_pkg;

    // Status codes of a result item.
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_SUCCESS = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Characters of the reply grammar.
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_R    = 8'h52;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       reply_ok;
        logic [3:0] lines_done;
        logic       char_valid;
        logic [2:0] char_line;
        logic [5:0] char_col;
        logic [7:0] char_value;
        logic       line_end;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/atrp_in_reg.sv =====
// Input register of the modem reply parser: holds one received item.
// Depends on atrp_pkg for the input item type.
`default_nettype none

module atrp_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire atrp_pkg::t_in_item i_item,
    output logic                   o_stall,
    output logic                   o_item_valid,
    output atrp_pkg::t_in_item     o_item,
    input  wire logic              i_take
);

    logic               r_valid;
    atrp_pkg::t_in_item r_item;
    logic               load;

    // Stall only while a held item cannot move on this cycle.
    assign o_stall      = r_valid && !i_take;
    assign load         = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/atrp_core.sv =====
// Parser state machine with line and column counters and the result register.
// Depends on atrp_pkg for item types, status codes and grammar characters.
`default_nettype none

module atrp_core #(
    parameter int MAX_LINES    = 8,
    parameter int MAX_LINE_LEN = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    input  wire atrp_pkg::t_in_item i_item,
    output logic                    o_take,
    output logic                    o_valid,
    output atrp_pkg::t_out_item     o_item,
    input  wire logic               i_stall
);

    localparam int LW = $clog2(MAX_LINES + 1);
    localparam int CW = $clog2(MAX_LINE_LEN + 1);

    typedef enum logic [4:0] {
        P_START, P_LF0, P_HEAD, P_LINE_FIRST, P_LINE_BODY, P_LINE_LF,
        P_LINE_DONE, P_TAIL_LF, P_FINAL, P_OK_K, P_END_CR, P_END_LF,
        P_E_R1, P_E_R2, P_E_O, P_E_R3, P_SUCCESS, P_ERROR
    } t_pstate;

    t_pstate             r_state, n_state, cur;
    logic [LW-1:0]       r_line, n_line;
    logic [CW-1:0]       r_col, n_col;
    logic                r_ok, n_ok;
    logic                r_out_valid;
    atrp_pkg::t_out_item r_out, n_out;

    logic          advance;
    logic          want_cap;
    logic          room;
    logic          cap;
    logic          ended;
    t_pstate       cap_next;
    logic [7:0]    c;

    assign advance = !r_out_valid || !i_stall;
    assign o_take  = i_item_valid && advance;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign c       = i_item.rx_byte;

    always_comb begin
        cur      = i_item.restart ? P_START : r_state;
        n_line   = r_line;
        n_col    = r_col;
        n_ok     = r_ok;
        want_cap = 1'b0;
        cap_next = P_ERROR;
        ended    = 1'b0;
        n_state  = P_ERROR;
        unique case (cur)
            P_START: begin
                n_line  = '0;
                n_col   = '0;
                n_ok    = 1'b0;
                n_state = (c == atrp_pkg::CH_CR) ? P_LF0 : P_ERROR;
            end
            P_LF0:   n_state = (c == atrp_pkg::CH_LF) ? P_HEAD : P_ERROR;
            P_HEAD, P_FINAL: begin
                priority if (c == atrp_pkg::CH_PLUS && cur == P_HEAD) begin
                    want_cap = 1'b1;
                    cap_next = P_LINE_FIRST;
                end else if (c == atrp_pkg::CH_O) begin
                    n_state = P_OK_K;
                end else if (c == atrp_pkg::CH_E) begin
                    n_state = P_E_R1;
                end else begin
                    n_state = P_ERROR;
                end
            end
            P_LINE_FIRST: begin
                if (c != atrp_pkg::CH_CR && c != atrp_pkg::CH_LF) begin
                    want_cap = 1'b1;
                    cap_next = P_LINE_BODY;
                end
            end
            P_LINE_BODY: begin
                priority if (c == atrp_pkg::CH_CR) begin
                    n_state = P_LINE_LF;
                end else if (c == atrp_pkg::CH_LF) begin
                    n_state = P_ERROR;
                end else begin
                    want_cap = 1'b1;
                    cap_next = P_LINE_BODY;
                end
            end
            P_LINE_LF: n_state = (c == atrp_pkg::CH_LF) ? P_LINE_DONE : P_ERROR;
            P_LINE_DONE: begin
                // Count the line on the byte after its CR LF, whatever that byte is.
                ended  = 1'b1;
                n_line = r_line + LW'(1);
                n_col  = '0;
                priority if (c == atrp_pkg::CH_CR) begin
                    n_state = P_TAIL_LF;
                end else if (c == atrp_pkg::CH_PLUS) begin
                    want_cap = 1'b1;
                    cap_next = P_LINE_FIRST;
                end else begin
                    n_state = P_ERROR;
                end
            end
            P_TAIL_LF: n_state = (c == atrp_pkg::CH_LF) ? P_FINAL : P_ERROR;
            P_OK_K: begin
                if (c == atrp_pkg::CH_K) begin
                    n_ok    = 1'b1;
                    n_state = P_END_CR;
                end
            end
            P_END_CR: n_state = (c == atrp_pkg::CH_CR) ? P_END_LF : P_ERROR;
            P_END_LF: n_state = (c == atrp_pkg::CH_LF) ? P_SUCCESS : P_ERROR;
            P_E_R1:   n_state = (c == atrp_pkg::CH_R) ? P_E_R2 : P_ERROR;
            P_E_R2:   n_state = (c == atrp_pkg::CH_R) ? P_E_O : P_ERROR;
            P_E_O:    n_state = (c == atrp_pkg::CH_O) ? P_E_R3 : P_ERROR;
            P_E_R3: begin
                if (c == atrp_pkg::CH_R) begin
                    n_ok    = 1'b0;
                    n_state = P_END_CR;
                end
            end
            P_SUCCESS: n_state = P_SUCCESS;
            default:   n_state = P_ERROR;
        endcase

        // Capture uses the counters as updated above; no room means error.
        room = (n_line < LW'(MAX_LINES)) && (n_col < CW'(MAX_LINE_LEN));
        cap  = want_cap && room;
        if (want_cap) begin
            n_state = room ? cap_next : P_ERROR;
        end

        n_out.status     = (n_state == P_SUCCESS) ? atrp_pkg::ST_SUCCESS :
                           (n_state == P_ERROR)   ? atrp_pkg::ST_ERROR   :
                                                    atrp_pkg::ST_BUSY;
        n_out.reply_ok   = n_ok;
        n_out.lines_done = 4'(n_line);
        n_out.char_valid = cap;
        n_out.char_line  = cap ? 3'(n_line) : 3'd0;
        n_out.char_col   = cap ? 6'(n_col) : 6'd0;
        n_out.char_value = cap ? c : 8'd0;
        n_out.line_end   = ended;

        if (cap) begin
            n_col = n_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= P_START;
            r_line      <= '0;
            r_col       <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_col       <= n_col;
            r_ok        <= n_ok;
            r_out_valid <= 1'b1;
        end else if (advance) begin
            r_out_valid <= 1'b0;
        end
        if (o_take) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/at_response_parser.sv =====
// Top level of the modem reply parser: input register feeding the parser core.
// Depends on atrp_pkg, atrp_in_reg and atrp_core.
//
// Usage:
//   Input channel (i_valid, i_item, o_stall): one received byte per item, with
//   restart set on the first byte of a new reply.
//   Output channel (o_valid, o_item, i_stall): one result item per input item,
//   in order: status, reply_ok, completed line count, and the captured line
//   character with its line and column, plus the line-completed flag.
//   Registers: an accepted item passes through the input register, then the
//   result register, before its result is valid and can be taken.
//   Throughput: one item per cycle while i_stall is low; the parser state
//   advances in one pass of logic as the item moves into the result register.
//   Reset (synchronous, active low): parser in its start state, counters and
//   the OK flag cleared, both registers empty.
//   Receiver stall: the result is held; an item is still taken into an empty
//   input register, after which o_stall rises until the result is taken.
`default_nettype none

module at_response_parser #(
    parameter int MAX_LINES    = 8,
    parameter int MAX_LINE_LEN = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire atrp_pkg::t_in_item  i_item,
    output logic                     o_stall,
    output logic                     o_valid,
    output atrp_pkg::t_out_item      o_item,
    input  wire logic                i_stall
);

    logic               held_valid;
    atrp_pkg::t_in_item held_item;
    logic               take;

    atrp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (i_item),
        .o_stall      (o_stall),
        .o_item_valid (held_valid),
        .o_item       (held_item),
        .i_take       (take)
    );

    atrp_core #(
        .MAX_LINES    (MAX_LINES),
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .o_take       (take),
        .o_valid      (o_valid),
        .o_item       (o_item),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire

// ===== rtl/atrp_checker.sv =====
// Port-level checker of the modem reply parser, bound to the top level.
// Depends on atrp_pkg and the macros in at_response_parser_assert.svh.
`default_nettype none
`include "at_response_parser_assert.svh"

module atrp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire atrp_pkg::t_in_item  i_item,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire atrp_pkg::t_out_item o_item,
    input wire logic                i_stall
);

    // Hold a stalled result and its payload.
    `ATRP_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && i_stall,
                      o_valid && $stable(o_item))

    // Hold a stalled input item.
    `ATRP_ASSERT_NEXT(a_in_item_holds, i_clk, i_rst_n, i_valid && o_stall,
                      i_valid && $stable(i_item))

    // Input stalls only behind a full, stalled result register.
    `ATRP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // A captured character always leaves the parser still busy.
    `ATRP_ASSERT_NOW(a_cap_busy, i_clk, i_rst_n, o_valid && o_item.char_valid,
                     o_item.status == atrp_pkg::ST_BUSY)

    // A line completes on any byte after its CR LF, never on the final byte.
    `ATRP_ASSERT_NOW(a_line_end_mid, i_clk, i_rst_n, o_valid && o_item.line_end,
                     o_item.status != atrp_pkg::ST_SUCCESS)

endmodule

bind at_response_parser atrp_checker u_atrp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_item  (i_item),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_item  (o_item),
    .i_stall (i_stall)
);

`default_nettype wire
